// ===== rtl/core/rhm_pkg.sv =====
// ----------------------------------------------------------------------------
// rhm_pkg
// Shared widths, status codes, constants and the exp2 table for the
// relative humidity pipeline.
// ----------------------------------------------------------------------------
package rhm_pkg;

  localparam int QV_W  = 24;
  localparam int P_W   = 17;
  localparam int TC_W  = 16;
  localparam int HUM_W = 15;
  localparam int ST_W  = 2;

  // saturation pressure, 2^-20 hPa; below 2^39 for any 16-bit temperature
  localparam int ES_W = 40;

  localparam int DIV_X_BITS = 23;  // quotient bits of the exponent argument
  localparam int EXP_BITS   = 16;  // fraction bits of the exp2 argument
  localparam int DIV_H_BITS = 15;  // humidity quotient bits

  // saturation pressure pipeline depth: input reg, divider, sign, log2e,
  // exp2 chain, scale, shift
  localparam int SP_LAT = 1 + DIV_X_BITS + 1 + 1 + EXP_BITS + 1 + 1;

  localparam logic [HUM_W-1:0] HUM_FULL  = HUM_W'(25600);
  localparam logic [31:0]      LOG2E_Q30 = 32'd1549082005;
  localparam logic [30:0]      ES0_Q28   = 31'd1640677507;

  typedef enum logic [ST_W-1:0] {
    ST_NORMAL = 2'd0,
    ST_ZERO   = 2'd1,
    ST_FULL   = 2'd2,
    ST_NODEN  = 2'd3
  } rhm_status_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] bv;
    r   = '0;
    rem = v;
    bv  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bv) begin
        rem = rem - (r + bv);
        r   = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    return r;
  endfunction

  // 2^(2^-b) in Q30, by repeated square roots
  function automatic logic [31:0] exp_rom(input int b);
    logic [63:0] r;
    r = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      if (i <= b) begin
        if (i == 1) begin
          r = isqrt64(64'd1 << 61);
        end else begin
          r = isqrt64(r << 30);
        end
      end
    end
    return r[31:0];
  endfunction

  localparam logic [31:0] EXP_ROM [EXP_BITS] = '{
    exp_rom(1),  exp_rom(2),  exp_rom(3),  exp_rom(4),
    exp_rom(5),  exp_rom(6),  exp_rom(7),  exp_rom(8),
    exp_rom(9),  exp_rom(10), exp_rom(11), exp_rom(12),
    exp_rom(13), exp_rom(14), exp_rom(15), exp_rom(16)
  };

endpackage

// ===== rtl/core/relative_humidity_from_mixing_ratio.sv =====
// ----------------------------------------------------------------------------
// relative_humidity_from_mixing_ratio
// Relative humidity from mixing ratio, pressure and temperature, fully
// pipelined.
// ----------------------------------------------------------------------------
// One item enters per clock and busy is always low, so start may be held high
// every cycle. Each item gives exactly one result, shown for a single cycle
// with out_valid high; the receiver cannot stall it and must take it then.
// Results leave in the order items came in. The pipeline has two parts:
// saturation pressure (a 23-stage divider for the exponent argument and a
// 16-stage multiply chain for 2^f) and the ratio (a 15-stage divider makes
// the humidity bits). Humidity is in 1/256 percent; status: normal, clamped
// to zero (negative mixing ratio), clamped to 100 percent, or no saturation
// denominator (forces 100 percent).
// ----------------------------------------------------------------------------
module relative_humidity_from_mixing_ratio
  import rhm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [QV_W-1:0] in_mixing_ratio,
  input  logic [P_W-1:0]         in_pressure_pa,
  input  logic [TC_W-1:0]        in_temp_centikelvin,
  output logic                   out_valid,
  output logic [HUM_W-1:0]       out_humidity,
  output logic [ST_W-1:0]        out_status
);

  typedef struct packed {
    logic signed [QV_W-1:0] qv;
    logic [P_W-1:0]         p;
  } side_t;

  logic            accept;
  logic            es_valid;
  logic [ES_W-1:0] es;
  side_t           side_r [SP_LAT];

  // never back-pressures
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // mixing ratio and pressure wait alongside the saturation pressure pipe
  always_ff @(posedge clk) begin
    side_r[0].qv <= in_mixing_ratio;
    side_r[0].p  <= in_pressure_pa;
    for (int i = 1; i < SP_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  rhm_sat_press u_sat_press (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .tc       (in_temp_centikelvin),
    .es_valid (es_valid),
    .es       (es)
  );

  rhm_ratio u_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (es_valid),
    .qv        (side_r[SP_LAT-1].qv),
    .p         (side_r[SP_LAT-1].p),
    .es        (es),
    .out_valid (out_valid),
    .humidity  (out_humidity),
    .status    (out_status)
  );

endmodule

// ===== rtl/core/rhm_sat_press.sv =====
// ----------------------------------------------------------------------------
// rhm_sat_press
// Pipelined saturation vapour pressure from temperature, 2^-20 hPa.
// ----------------------------------------------------------------------------
module rhm_sat_press
  import rhm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [TC_W-1:0] tc,
  output logic            es_valid,
  output logic [ES_W-1:0] es
);

  localparam logic [TC_W-1:0] TC_ZERO_C = TC_W'(27315);
  localparam logic [TC_W-1:0] TC_POLE_C = TC_W'(2965);
  localparam int NUM_W = 44;
  localparam int DEN_W = 23;
  localparam int DSH_W = DEN_W + DIV_X_BITS;
  localparam int X_W   = DIV_X_BITS + 1;
  localparam int IP_W  = 8;
  localparam logic [DIV_X_BITS-1:0] X_MIN_C   = DIV_X_BITS'(4194304);
  localparam logic [IP_W-1:0]       ES_SHIFT_C = IP_W'(166);

  typedef struct packed {
    logic                  neg;
    logic                  cold;
    logic                  ovf;
    logic [NUM_W-1:0]      rem;
    logic [DEN_W-1:0]      den;
    logic [DIV_X_BITS-1:0] quo;
  } xdiv_t;

  typedef struct packed {
    logic                zero;
    logic [IP_W-1:0]     ip;
    logic [EXP_BITS-1:0] frac;
    logic [31:0]         m;
  } exp_t;

  // input stage
  logic              neg_c;
  logic              cold_c;
  logic [TC_W-1:0]   absd_c;
  logic [TC_W-1:0]   offs_c;
  logic [26:0]       mag_c;
  logic [DEN_W-1:0]  den_c;

  assign neg_c  = tc < TC_ZERO_C;
  assign absd_c = neg_c ? TC_ZERO_C - tc : tc - TC_ZERO_C;
  assign cold_c = tc <= TC_POLE_C;
  assign offs_c = tc - TC_POLE_C;
  assign mag_c  = 27'(absd_c) * 27'd1767;
  assign den_c  = cold_c ? '0 : DEN_W'(offs_c) * DEN_W'(100);

  // restoring divider, one quotient bit a stage
  xdiv_t               xd_r   [DIV_X_BITS+1];
  xdiv_t               xd_nxt [DIV_X_BITS+1];
  logic [DIV_X_BITS:0] xv_r;

  always_comb begin
    xd_nxt[0].neg  = neg_c;
    xd_nxt[0].cold = cold_c;
    xd_nxt[0].ovf  = 1'b0;
    xd_nxt[0].rem  = NUM_W'({mag_c, 16'd0});
    xd_nxt[0].den  = den_c;
    xd_nxt[0].quo  = '0;
    for (int i = 0; i < DIV_X_BITS; i++) begin
      xd_nxt[i+1] = xd_r[i];
      if ({2'b00, xd_r[i].rem} >= (DSH_W'(xd_r[i].den) << (DIV_X_BITS-1-i))) begin
        xd_nxt[i+1].rem = xd_r[i].rem -
                          NUM_W'(DSH_W'(xd_r[i].den) << (DIV_X_BITS-1-i));
        xd_nxt[i+1].quo[DIV_X_BITS-1-i] = 1'b1;
      end
    end
    // quotient would not fit: far below the clamp
    xd_nxt[1].ovf = {2'b00, xd_r[0].rem} >= {xd_r[0].den, DIV_X_BITS'(0)};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= DIV_X_BITS; i++) begin
      xd_r[i] <= xd_nxt[i];
    end
  end

  // sign and cold clamp
  logic                  tooc_c;
  logic signed [X_W-1:0] xval_c;
  logic signed [X_W-1:0] x_r;
  logic                  xz_r;
  logic                  vx_r;

  assign tooc_c = xd_r[DIV_X_BITS].cold |
                  (xd_r[DIV_X_BITS].neg &
                   (xd_r[DIV_X_BITS].ovf | (xd_r[DIV_X_BITS].quo > X_MIN_C)));
  assign xval_c = xd_r[DIV_X_BITS].neg ? -$signed({1'b0, xd_r[DIV_X_BITS].quo})
                                       :  $signed({1'b0, xd_r[DIV_X_BITS].quo});

  always_ff @(posedge clk) begin
    x_r  <= xval_c;
    xz_r <= tooc_c;
  end

  // to base 2 with offset 128, then 2^f by a chain of table multiplies
  logic signed [56:0] yq_c;
  exp_t               em_r   [EXP_BITS+1];
  exp_t               em_nxt [EXP_BITS+1];
  logic [63:0]        mp_c   [EXP_BITS];
  logic [EXP_BITS:0]  ev_r;

  assign yq_c = 57'(x_r) * $signed({1'b0, LOG2E_Q30}) + (57'sd1 <<< 53);

  always_comb begin
    em_nxt[0].zero = xz_r;
    em_nxt[0].ip   = yq_c[53:46];
    em_nxt[0].frac = yq_c[45:30];
    em_nxt[0].m    = 32'd1 << 30;
    for (int b = 1; b <= EXP_BITS; b++) begin
      em_nxt[b]  = em_r[b-1];
      mp_c[b-1]  = 64'(em_r[b-1].m) * 64'(EXP_ROM[b-1]) + (64'd1 << 29);
      if (em_r[b-1].frac[EXP_BITS-b]) begin
        em_nxt[b].m = mp_c[b-1][61:30];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b <= EXP_BITS; b++) begin
      em_r[b] <= em_nxt[b];
    end
  end

  // scale by 6.112 hPa, then shift into place
  logic [62:0]     pr_r;
  logic [IP_W-1:0] pip_r;
  logic            pz_r;
  logic            vp_r;
  logic [IP_W-1:0] sh_c;
  logic [62:0]     shv_c;
  logic [ES_W-1:0] es_r;
  logic            vs_r;

  always_ff @(posedge clk) begin
    pr_r  <= 63'(em_r[EXP_BITS].m) * 63'(ES0_Q28);
    pip_r <= em_r[EXP_BITS].ip;
    pz_r  <= em_r[EXP_BITS].zero;
  end

  always_comb begin
    sh_c = ES_SHIFT_C - pip_r;
    if (pip_r >= ES_SHIFT_C) begin
      shv_c = pr_r;
    end else if (sh_c >= IP_W'(64)) begin
      shv_c = '0;
    end else begin
      shv_c = pr_r >> sh_c[5:0];
    end
  end

  always_ff @(posedge clk) begin
    es_r <= pz_r ? '0 : shv_c[ES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xv_r <= '0;
      vx_r <= 1'b0;
      ev_r <= '0;
      vp_r <= 1'b0;
      vs_r <= 1'b0;
    end else begin
      xv_r <= {xv_r[DIV_X_BITS-1:0], in_valid};
      vx_r <= xv_r[DIV_X_BITS];
      ev_r <= {ev_r[EXP_BITS-1:0], vx_r};
      vp_r <= ev_r[EXP_BITS];
      vs_r <= vp_r;
    end
  end

  assign es_valid = vs_r;
  assign es       = es_r;

endmodule

// ===== rtl/core/rhm_ratio.sv =====
// ----------------------------------------------------------------------------
// rhm_ratio
// Pipelined qv/QVS ratio, special cases and scaling to 1/256 percent.
// ----------------------------------------------------------------------------
module rhm_ratio
  import rhm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic signed [QV_W-1:0] qv,
  input  logic [P_W-1:0]         p,
  input  logic [ES_W-1:0]        es,
  output logic                   out_valid,
  output logic [HUM_W-1:0]       humidity,
  output logic [ST_W-1:0]        status
);

  localparam int P5_W  = 20;
  localparam int E189_W = 48;
  localparam int DEN_W = 49;
  localparam int DP_W  = 50;
  localparam int DPL_W = 40;
  localparam int QM_W  = QV_W - 1;
  localparam int PP_W  = QM_W + DPL_W / 2;
  localparam int Q_W   = 63;
  localparam int RS_W  = Q_W + 15;
  localparam int RN_W  = RS_W - 24;
  localparam int DSH_W = 64;

  typedef struct packed {
    logic              spec;
    logic [HUM_W-1:0]  sh;
    rhm_status_t       sst;
    logic [RN_W-1:0]   rem;
    logic [DEN_W-1:0]  den;
    logic [HUM_W-1:0]  quo;
  } hdiv_t;

  // stage 1: constant products
  logic                   v1_r;
  logic signed [QV_W-1:0] qv1_r;
  logic [P5_W-1:0]        p5_r;
  logic [E189_W-1:0]      e189_r;
  logic [DEN_W-1:0]       d311_r;
  logic                   ez1_r;

  always_ff @(posedge clk) begin
    qv1_r  <= qv;
    p5_r   <= P5_W'(p) * P5_W'(5);
    e189_r <= E189_W'(es) * E189_W'(189);
    d311_r <= DEN_W'(es) * DEN_W'(311);
    ez1_r  <= es == '0;
  end

  // stage 2: denominator and early outcomes
  logic signed [DP_W-1:0] dp_c;
  logic                   spec_c;
  logic [HUM_W-1:0]       sh_c;
  rhm_status_t            sst_c;

  assign dp_c = $signed({10'd0, p5_r, 20'd0}) - $signed({2'd0, e189_r});

  always_comb begin
    spec_c = 1'b1;
    sh_c   = HUM_FULL;
    sst_c  = ST_NODEN;
    if (dp_c <= 0) begin
      sh_c  = HUM_FULL;
      sst_c = ST_NODEN;
    end else if (qv1_r == 0) begin
      sh_c  = '0;
      sst_c = ST_NORMAL;
    end else if (qv1_r < 0) begin
      sh_c  = '0;
      sst_c = ST_ZERO;
    end else if (ez1_r) begin
      sh_c  = HUM_FULL;
      sst_c = ST_FULL;
    end else begin
      spec_c = 1'b0;
      sh_c   = '0;
      sst_c  = ST_NORMAL;
    end
  end

  logic             v2_r;
  logic             spec2_r;
  logic [HUM_W-1:0] sh2_r;
  rhm_status_t      sst2_r;
  logic [DPL_W-1:0] dpl2_r;
  logic [DEN_W-1:0] den2_r;
  logic [QM_W-1:0]  qvm2_r;

  always_ff @(posedge clk) begin
    spec2_r <= spec_c;
    sh2_r   <= sh_c;
    sst2_r  <= sst_c;
    dpl2_r  <= dp_c[DPL_W-1:0];
    den2_r  <= d311_r;
    qvm2_r  <= qv1_r[QM_W-1:0];
  end

  // stage 3: partial products of qv * D
  logic             v3_r;
  logic             spec3_r;
  logic [HUM_W-1:0] sh3_r;
  rhm_status_t      sst3_r;
  logic [DEN_W-1:0] den3_r;
  logic [PP_W-1:0]  ppl3_r;
  logic [PP_W-1:0]  pph3_r;

  always_ff @(posedge clk) begin
    spec3_r <= spec2_r;
    sh3_r   <= sh2_r;
    sst3_r  <= sst2_r;
    den3_r  <= den2_r;
    ppl3_r  <= PP_W'(qvm2_r) * PP_W'(dpl2_r[DPL_W/2-1:0]);
    pph3_r  <= PP_W'(qvm2_r) * PP_W'(dpl2_r[DPL_W-1:DPL_W/2]);
  end

  // stage 4: sum
  logic             v4_r;
  logic             spec4_r;
  logic [HUM_W-1:0] sh4_r;
  rhm_status_t      sst4_r;
  logic [DEN_W-1:0] den4_r;
  logic [Q_W-1:0]   q4_r;

  always_ff @(posedge clk) begin
    spec4_r <= spec3_r;
    sh4_r   <= sh3_r;
    sst4_r  <= sst3_r;
    den4_r  <= den3_r;
    q4_r    <= Q_W'(ppl3_r) + (Q_W'(pph3_r) << (DPL_W/2));
  end

  // stage 5: saturation test and numerator 25600*q/2^24
  logic            big_c;
  logic [RS_W-1:0] rs_c;

  assign big_c = {10'd0, q4_r[Q_W-1:24]} >= den4_r;
  assign rs_c  = (RS_W'(q4_r) << 14) + (RS_W'(q4_r) << 13) + (RS_W'(q4_r) << 10);

  hdiv_t               hd_r   [DIV_H_BITS+1];
  hdiv_t               hd_nxt [DIV_H_BITS+1];
  logic [DIV_H_BITS:0] hv_r;

  always_comb begin
    hd_nxt[0].spec = spec4_r | big_c;
    hd_nxt[0].sh   = spec4_r ? sh4_r  : HUM_FULL;
    hd_nxt[0].sst  = spec4_r ? sst4_r : ST_FULL;
    hd_nxt[0].rem  = rs_c[RS_W-1:24];
    hd_nxt[0].den  = den4_r;
    hd_nxt[0].quo  = '0;
    for (int i = 0; i < DIV_H_BITS; i++) begin
      hd_nxt[i+1] = hd_r[i];
      if (DSH_W'(hd_r[i].rem) >= (DSH_W'(hd_r[i].den) << (DIV_H_BITS-1-i))) begin
        hd_nxt[i+1].rem = hd_r[i].rem -
                          RN_W'(DSH_W'(hd_r[i].den) << (DIV_H_BITS-1-i));
        hd_nxt[i+1].quo[DIV_H_BITS-1-i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= DIV_H_BITS; i++) begin
      hd_r[i] <= hd_nxt[i];
    end
  end

  // output register
  logic             vo_r;
  logic [HUM_W-1:0] hum_r;
  rhm_status_t      st_r;

  always_ff @(posedge clk) begin
    hum_r <= hd_r[DIV_H_BITS].spec ? hd_r[DIV_H_BITS].sh  : hd_r[DIV_H_BITS].quo;
    st_r  <= hd_r[DIV_H_BITS].spec ? hd_r[DIV_H_BITS].sst : ST_NORMAL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      hv_r <= '0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      hv_r <= {hv_r[DIV_H_BITS-1:0], v4_r};
      vo_r <= hv_r[DIV_H_BITS];
    end
  end

  assign out_valid = vo_r;
  assign humidity  = hum_r;
  assign status    = st_r;

endmodule
